// File: src/cal_clk_pkg.sv
// Shared types, constants and helper functions for the calendar clock counter.
// No dependencies; every other source file imports this package.
package cal_clk_pkg;

  localparam int YearW    = 14;
  localparam int MonthW   = 4;
  localparam int DayW     = 5;
  localparam int HourW    = 5;
  localparam int MinuteW  = 6;
  localparam int SecondW  = 6;
  localparam int WeekdayW = 3;
  localparam int StampW   = 32;
  localparam int UptimeW  = 32;
  localparam int TpsW     = 16;
  localparam int Mod25W   = 5;

  localparam int InDataW  = 80;
  localparam int OutDataW = 112;

  localparam logic [TpsW-1:0]     TpsReset     = 16'd1000;
  localparam logic [YearW-1:0]    YearReset    = 14'd2022;
  localparam logic [Mod25W-1:0]   YearMod25Rst = 5'd22;
  localparam logic [DayW-1:0]     DayReset     = 5'd1;

  localparam logic [SecondW-1:0]  SecondMax    = 6'd59;
  localparam logic [MinuteW-1:0]  MinuteMax    = 6'd59;
  localparam logic [HourW-1:0]    HourMax      = 5'd23;
  localparam logic [WeekdayW-1:0] WeekdayMax   = 3'd6;
  localparam logic [MonthW-1:0]   MonthMax     = 4'd11;
  localparam logic [MonthW-1:0]   MonthFeb     = 4'd1;
  localparam logic [YearW-1:0]    YearTop      = 14'h3FFF;
  localparam logic [Mod25W-1:0]   Mod25Max     = 5'd24;

  // floor(y / 25) == (y * Recip25) >> Recip25Shift for every 14-bit y
  localparam logic [14:0]         Recip25      = 15'd20972;
  localparam int                  Recip25Shift = 19;

  localparam logic ActTick = 1'b0;
  localparam logic ActLoad = 1'b1;

  typedef struct packed {
    logic                action;
    logic [YearW-1:0]    year;
    logic [Mod25W-1:0]   year_mod25;
    logic [MonthW-1:0]   month;
    logic [DayW-1:0]     day;
    logic [HourW-1:0]    hour;
    logic [MinuteW-1:0]  minute;
    logic [SecondW-1:0]  second;
    logic [WeekdayW-1:0] weekday;
    logic [StampW-1:0]   stamp;
  } cal_clk_item_t;

  // Month length; months past December count as 31 days.
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    begin
      case (m)
        4'd1:                      len = 5'd28;
        4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
        default:                   len = 5'd31;
      endcase
      if (m == MonthFeb && leap) begin
        len = 5'd29;
      end
      return len;
    end
  endfunction

  // Gregorian leap test from the low year bits and the year modulo 25.
  function automatic logic is_leap(input logic [YearW-1:0] y,
                                   input logic [Mod25W-1:0] y_mod25);
    begin
      return (y[1:0] == 2'd0) && ((y_mod25 != '0) || (y[3:0] == 4'd0));
    end
  endfunction

endpackage

// File: src/cal_clk_in_stage.sv
// Input register of the calendar clock counter: unpacks and holds one request,
// and works out the loaded year modulo 25. Depends on cal_clk_pkg.
module cal_clk_in_stage (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // load_year, load_month, load_day, load_hour, load_minute, load_second,
  // load_weekday, load_stamp from bit 0 up, zero filled to 80 bits
  input  logic [cal_clk_pkg::InDataW-1:0]   s_axis_tdata,
  // action
  input  logic                              s_axis_tuser,
  input  logic                              adv,
  output logic                              item_valid,
  output cal_clk_pkg::cal_clk_item_t        item
);
  import cal_clk_pkg::*;

  logic                  take;
  logic [YearW-1:0]      in_year;
  logic [28:0]           recip_prod;
  logic [9:0]            quot;
  logic [YearW-1:0]      quot_x25;
  logic [YearW-1:0]      rem_full;
  cal_clk_item_t         item_next;

  assign s_axis_tready = !item_valid || adv;
  assign take          = s_axis_tvalid && s_axis_tready;

  assign in_year    = s_axis_tdata[13:0];
  assign recip_prod = {15'd0, in_year} * {14'd0, Recip25};
  assign quot       = recip_prod[28:Recip25Shift];
  assign quot_x25   = YearW'({quot, 4'd0}) + YearW'({quot, 3'd0}) + YearW'(quot);
  assign rem_full   = in_year - quot_x25;

  always_comb begin
    item_next.action     = s_axis_tuser;
    item_next.year       = in_year;
    item_next.year_mod25 = rem_full[Mod25W-1:0];
    item_next.month      = s_axis_tdata[17:14];
    item_next.day        = s_axis_tdata[22:18];
    item_next.hour       = s_axis_tdata[27:23];
    item_next.minute     = s_axis_tdata[33:28];
    item_next.second     = s_axis_tdata[39:34];
    item_next.weekday    = s_axis_tdata[42:40];
    item_next.stamp      = s_axis_tdata[74:43];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (adv) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= item_next;
    end
  end

endmodule

// File: src/cal_clk_core.sv
// Calendar state, single-pass rollover cascade and result register.
// Depends on cal_clk_pkg; fed by cal_clk_in_stage.
module cal_clk_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [cal_clk_pkg::TpsW-1:0]      ticks_per_second,
  input  logic                              item_valid,
  input  cal_clk_pkg::cal_clk_item_t        item,
  output logic                              adv,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // year, month, day, hour, minute, second, weekday, epoch_seconds,
  // uptime_ms from bit 0 up, zero filled to 112 bits
  output logic [cal_clk_pkg::OutDataW-1:0]  m_axis_tdata,
  // second_pulse
  output logic                              m_axis_tuser
);
  import cal_clk_pkg::*;

  logic [TpsW-1:0]     prescaler,  prescaler_next;
  logic [SecondW-1:0]  second,     second_next;
  logic [MinuteW-1:0]  minute,     minute_next;
  logic [HourW-1:0]    hour,       hour_next;
  logic [DayW-1:0]     day,        day_next;
  logic [MonthW-1:0]   month,      month_next;
  logic [YearW-1:0]    year,       year_next;
  logic [Mod25W-1:0]   year_mod25, year_mod25_next;
  logic [WeekdayW-1:0] weekday,    weekday_next;
  logic [StampW-1:0]   stamp,      stamp_next;
  logic [UptimeW-1:0]  uptime,     uptime_next;

  logic                step;
  logic                tick;
  logic [TpsW:0]       pre_inc;
  logic                sec_done;
  logic                sec_carry, min_carry, hour_carry, day_carry, month_carry;
  logic [DayW-1:0]     cur_len;
  logic                pulse_next;

  assign adv  = !m_axis_tvalid || m_axis_tready;
  assign step = item_valid && adv;
  assign tick = (item.action == ActTick);

  assign pre_inc  = {1'b0, prescaler} + {{TpsW{1'b0}}, 1'b1};
  assign sec_done = tick && (pre_inc >= {1'b0, ticks_per_second});
  assign cur_len  = month_len(month, is_leap(year, year_mod25));

  // rollover cascade: each unit carries when it sits at or above its maximum
  assign sec_carry   = sec_done    && (second  >= SecondMax);
  assign min_carry   = sec_carry   && (minute  >= MinuteMax);
  assign hour_carry  = min_carry   && (hour    >= HourMax);
  assign day_carry   = hour_carry  && (day     >= cur_len);
  assign month_carry = day_carry   && (month   >= MonthMax);

  always_comb begin
    prescaler_next  = prescaler;
    second_next     = second;
    minute_next     = minute;
    hour_next       = hour;
    day_next        = day;
    month_next      = month;
    year_next       = year;
    year_mod25_next = year_mod25;
    weekday_next    = weekday;
    stamp_next      = stamp;
    uptime_next     = uptime;
    pulse_next      = 1'b0;
    if (!tick) begin
      year_next       = item.year;
      year_mod25_next = item.year_mod25;
      month_next      = item.month;
      day_next        = item.day;
      hour_next       = item.hour;
      minute_next     = item.minute;
      second_next     = item.second;
      weekday_next    = item.weekday;
      stamp_next      = item.stamp;
    end else begin
      uptime_next    = uptime + 32'd1;
      prescaler_next = sec_done ? '0 : pre_inc[TpsW-1:0];
      if (sec_done) begin
        pulse_next  = 1'b1;
        stamp_next  = stamp + 32'd1;
        second_next = sec_carry ? '0 : second + 6'd1;
      end
      if (sec_carry) begin
        minute_next = min_carry ? '0 : minute + 6'd1;
      end
      if (min_carry) begin
        hour_next = hour_carry ? '0 : hour + 5'd1;
      end
      if (hour_carry) begin
        weekday_next = (weekday >= WeekdayMax) ? '0 : weekday + 3'd1;
        day_next     = day_carry ? DayReset : day + 5'd1;
      end
      if (day_carry) begin
        month_next = month_carry ? '0 : month + 4'd1;
      end
      if (month_carry) begin
        year_next = year + 14'd1;
        // keep the modulo-25 shadow in step, including the wrap to year 0
        if (year == YearTop || year_mod25 >= Mod25Max) begin
          year_mod25_next = '0;
        end else begin
          year_mod25_next = year_mod25 + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescaler  <= '0;
      second     <= '0;
      minute     <= '0;
      hour       <= '0;
      day        <= DayReset;
      month      <= '0;
      year       <= YearReset;
      year_mod25 <= YearMod25Rst;
      weekday    <= '0;
      stamp      <= '0;
      uptime     <= '0;
    end else if (step) begin
      prescaler  <= prescaler_next;
      second     <= second_next;
      minute     <= minute_next;
      hour       <= hour_next;
      day        <= day_next;
      month      <= month_next;
      year       <= year_next;
      year_mod25 <= year_mod25_next;
      weekday    <= weekday_next;
      stamp      <= stamp_next;
      uptime     <= uptime_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_axis_tdata <= {5'd0, uptime_next, stamp_next, weekday_next, second_next,
                       minute_next, hour_next, day_next, month_next, year_next};
      m_axis_tuser <= pulse_next;
    end
  end

  a_mod25_range: assert property (@(posedge clk) disable iff (rst)
    year_mod25 <= Mod25Max)
    else $error("year modulo-25 shadow out of range");

  a_tick_uptime: assert property (@(posedge clk) disable iff (rst)
    step && tick |=> uptime == $past(uptime) + 32'd1)
    else $error("uptime did not advance on a tick");

  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(uptime) && $stable(stamp) && $stable(prescaler))
    else $error("state changed without a request");

  a_load_stamp: assert property (@(posedge clk) disable iff (rst)
    step && !tick |=> stamp == $past(item.stamp) && !m_axis_tuser)
    else $error("load did not set the timestamp");

  a_pulse_stamp: assert property (@(posedge clk) disable iff (rst)
    step && sec_done |=> stamp == $past(stamp) + 32'd1 && prescaler == '0)
    else $error("completed second did not advance the timestamp");

endmodule

// File: src/calendar_clock_counter_top.sv
// Top level of the calendar clock counter: configuration register and the two
// pipeline stages. Depends on cal_clk_pkg, cal_clk_in_stage and cal_clk_core.
//
// Each request is either a millisecond tick (tuser low) or a load of the
// calendar, weekday and epoch timestamp (tuser high); each produces exactly one
// result showing the calendar after that request. The block takes one request
// per cycle unless the result side stalls; each goes from the input register
// through the rollover cascade into the result register. The whole
// second-to-year rollover, including the Gregorian leap test, is resolved in
// the cascade; the leap test uses a year-modulo-25 value kept beside the year,
// computed from the loaded year in the input stage. ticks_per_second (reset
// 1000) is written through cfg_wr_en / cfg_wr_data, by the user only while
// the block is idle (not enforced); zero makes every tick complete a second.
module calendar_clock_counter_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [cal_clk_pkg::TpsW-1:0]      cfg_wr_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // load_year, load_month, load_day, load_hour, load_minute, load_second,
  // load_weekday, load_stamp from bit 0 up, zero filled to 80 bits
  input  logic [cal_clk_pkg::InDataW-1:0]   s_axis_tdata,
  // action
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // year, month, day, hour, minute, second, weekday, epoch_seconds,
  // uptime_ms from bit 0 up, zero filled to 112 bits
  output logic [cal_clk_pkg::OutDataW-1:0]  m_axis_tdata,
  // second_pulse
  output logic                              m_axis_tuser
);
  import cal_clk_pkg::*;

  logic [TpsW-1:0] ticks_per_second;
  logic            adv;
  logic            item_valid;
  cal_clk_item_t   item;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= TpsReset;
    end else if (cfg_wr_en) begin
      ticks_per_second <= cfg_wr_data;
    end
  end

  cal_clk_in_stage u_in_stage (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .adv           (adv),
    .item_valid    (item_valid),
    .item          (item)
  );

  cal_clk_core u_core (
    .clk              (clk),
    .rst              (rst),
    .ticks_per_second (ticks_per_second),
    .item_valid       (item_valid),
    .item             (item),
    .adv              (adv),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser)
  );

endmodule

// File: verif/tb_calendar_clock_counter_top.sv
// Self-checking testbench for calendar_clock_counter_top: directed calendar edges
// and random tick/load traffic, checked against typed readings or an in-bench calendar predictor.
// Depends on cal_clk_pkg and the calendar_clock_counter_top RTL.
`timescale 1ns / 1ps

module tb_calendar_clock_counter_top;
  import cal_clk_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // Load fields, year in the lowest bits as on s_axis_tdata.
  typedef struct packed {
    logic [StampW-1:0]   stamp;
    logic [WeekdayW-1:0] weekday;
    logic [SecondW-1:0]  second;
    logic [MinuteW-1:0]  minute;
    logic [HourW-1:0]    hour;
    logic [DayW-1:0]     day;
    logic [MonthW-1:0]   month;
    logic [YearW-1:0]    year;
  } load_req_t;

  // Calendar reading: second_pulse on top of the m_axis_tdata fields.
  typedef struct packed {
    logic                pulse;
    logic [UptimeW-1:0]  uptime;
    logic [StampW-1:0]   epoch;
    logic [WeekdayW-1:0] weekday;
    logic [SecondW-1:0]  second;
    logic [MinuteW-1:0]  minute;
    logic [HourW-1:0]    hour;
    logic [DayW-1:0]     day;
    logic [MonthW-1:0]   month;
    logic [YearW-1:0]    year;
  } cal_reading_t;

  typedef struct {
    int           rate;   // tick rate to write before the request, -1 for none
    logic         act;
    load_req_t    ld;
    logic         known;
    cal_reading_t want;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [TpsW-1:0]     cfg_wr_data = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  // Predictor state
  logic [TpsW-1:0]     tick_rate = TpsReset;
  logic [TpsW-1:0]     now_presc = '0;
  logic [YearW-1:0]    now_year = YearReset;
  logic [MonthW-1:0]   now_month = '0;
  logic [DayW-1:0]     now_day = DayReset;
  logic [HourW-1:0]    now_hour = '0;
  logic [MinuteW-1:0]  now_minute = '0;
  logic [SecondW-1:0]  now_second = '0;
  logic [WeekdayW-1:0] now_weekday = '0;
  logic [StampW-1:0]   now_stamp = '0;
  logic [UptimeW-1:0]  now_uptime = '0;

  cal_reading_t readings_due [$];
  plan_row_t    plan [21];
  bit           steady = 1'b0;
  int unsigned  cycle_count = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  readings_checked = 0;
  int unsigned  pulse_count = 0;
  int unsigned  tick_count = 0;
  int unsigned  load_count = 0;

  calendar_clock_counter_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int days_in(input logic [MonthW-1:0] m, input logic [YearW-1:0] y);
    int yi;
    yi = y;
    if (m > MonthMax) return 31;
    if (m == MonthFeb) begin
      return (((yi % 4) == 0 && (yi % 100) != 0) || (yi % 400) == 0) ? 29 : 28;
    end
    return MonthDays[m];
  endfunction

  // Apply one request to the predictor state and return the reading it leaves.
  function automatic cal_reading_t step_calendar(input logic act, input load_req_t ld);
    cal_reading_t r;
    logic [TpsW:0] nxt;
    r = '0;
    if (act == ActLoad) begin
      now_year    = ld.year;
      now_month   = ld.month;
      now_day     = ld.day;
      now_hour    = ld.hour;
      now_minute  = ld.minute;
      now_second  = ld.second;
      now_weekday = ld.weekday;
      now_stamp   = ld.stamp;
    end else begin
      now_uptime = now_uptime + 1'b1;
      nxt = {1'b0, now_presc} + 1'b1;
      if (nxt >= {1'b0, tick_rate}) begin
        now_presc = '0;
        r.pulse = 1'b1;
        now_stamp = now_stamp + 1'b1;
        // Compare before incrementing so out-of-range values roll to zero.
        if (now_second < SecondMax) begin
          now_second++;
        end else begin
          now_second = '0;
          if (now_minute < MinuteMax) begin
            now_minute++;
          end else begin
            now_minute = '0;
            if (now_hour < HourMax) begin
              now_hour++;
            end else begin
              now_hour = '0;
              now_weekday = (now_weekday < WeekdayMax) ? now_weekday + 1'b1 : '0;
              if (int'(now_day) + 1 > days_in(now_month, now_year)) begin
                now_day = 5'd1;
                if (now_month < MonthMax) begin
                  now_month++;
                end else begin
                  now_month = '0;
                  now_year = now_year + 1'b1;
                end
              end else begin
                now_day++;
              end
            end
          end
        end
      end else begin
        now_presc = nxt[TpsW-1:0];
      end
    end
    r.year    = now_year;
    r.month   = now_month;
    r.day     = now_day;
    r.hour    = now_hour;
    r.minute  = now_minute;
    r.second  = now_second;
    r.weekday = now_weekday;
    r.epoch   = now_stamp;
    r.uptime  = now_uptime;
    return r;
  endfunction

  function automatic load_req_t load_of(input int y, mo, d, h, mi, s, wd,
                                        input longint unsigned st);
    load_req_t ld;
    ld.year    = 14'(y);
    ld.month   = 4'(mo);
    ld.day     = 5'(d);
    ld.hour    = 5'(h);
    ld.minute  = 6'(mi);
    ld.second  = 6'(s);
    ld.weekday = 3'(wd);
    ld.stamp   = 32'(st);
    return ld;
  endfunction

  function automatic cal_reading_t reading_of(input int y, mo, d, h, mi, s, wd,
                                              input longint unsigned ep, up,
                                              input int p);
    cal_reading_t r;
    r.year    = 14'(y);
    r.month   = 4'(mo);
    r.day     = 5'(d);
    r.hour    = 5'(h);
    r.minute  = 6'(mi);
    r.second  = 6'(s);
    r.weekday = 3'(wd);
    r.epoch   = 32'(ep);
    r.uptime  = 32'(up);
    r.pulse   = 1'(p);
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input longint unsigned want,
                               input longint unsigned got);
    if (mismatch_count < 30) begin
      $display("mismatch on reading %0d: %s expected %0h got %0h",
               readings_checked, what, want, got);
    end
    mismatch_count++;
  endtask

  task automatic check_reading(input cal_reading_t want, input cal_reading_t got);
    if (got.year != want.year)       flag_mismatch("year", want.year, got.year);
    if (got.month != want.month)     flag_mismatch("month", want.month, got.month);
    if (got.day != want.day)         flag_mismatch("day", want.day, got.day);
    if (got.hour != want.hour)       flag_mismatch("hour", want.hour, got.hour);
    if (got.minute != want.minute)   flag_mismatch("minute", want.minute, got.minute);
    if (got.second != want.second)   flag_mismatch("second", want.second, got.second);
    if (got.weekday != want.weekday) flag_mismatch("weekday", want.weekday, got.weekday);
    if (got.epoch != want.epoch)     flag_mismatch("epoch_seconds", want.epoch, got.epoch);
    if (got.uptime != want.uptime)   flag_mismatch("uptime_ms", want.uptime, got.uptime);
    if (got.pulse != want.pulse)     flag_mismatch("second_pulse", want.pulse, got.pulse);
  endtask

  // Send one request; queue the typed reading if given, else the predicted one.
  task automatic push_request(input logic act, input load_req_t ld, input logic known,
                              input cal_reading_t want);
    cal_reading_t due;
    while (!steady && $urandom_range(99) < 36) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {{(InDataW - $bits(load_req_t)){1'b0}}, ld};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    due = step_calendar(act, ld);
    readings_due.push_back(known ? want : due);
    if (act == ActLoad) load_count++;
    else tick_count++;
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_tick_rate(input logic [TpsW-1:0] rate);
    wait_drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= rate;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tick_rate = rate;
  endtask

  // Result side: random backpressure, check each accepted reading in order.
  always @(posedge clk) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 36);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (readings_due.size() == 0) begin
        flag_mismatch("reading with none pending", 0, m_axis_tdata[63:0]);
      end else begin
        check_reading(readings_due.pop_front(),
                      {m_axis_tuser, m_axis_tdata[$bits(cal_reading_t)-2:0]});
      end
      if (m_axis_tuser) pulse_count++;
      readings_checked++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout with %0d readings pending", readings_due.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int            i;
    int            p;
    int            load_pct;
    logic [95:0]   raw;
    load_req_t     ld;
    logic [TpsW-1:0] phase_rate [8];
    int            phase_len [8];

    plan = '{
      '{-1, ActTick, '0, 1'b1, reading_of(2022, 0, 1, 0, 0, 0, 0, 0, 1, 0)},
      // lowered rate: prescaler already at the new limit
      '{2, ActTick, '0, 1'b1, reading_of(2022, 0, 1, 0, 0, 1, 0, 1, 2, 1)},
      '{0, ActTick, '0, 1'b1, reading_of(2022, 0, 1, 0, 0, 2, 0, 2, 3, 1)},
      '{-1, ActLoad, load_of(16383, 11, 31, 23, 59, 59, 6, 64'hFFFF_FFFF), 1'b1,
        reading_of(16383, 11, 31, 23, 59, 59, 6, 64'hFFFF_FFFF, 3, 0)},
      // year, timestamp and every calendar field wrap together
      '{-1, ActTick, '0, 1'b1, reading_of(0, 0, 1, 0, 0, 0, 0, 0, 4, 1)},
      '{-1, ActLoad, load_of(2024, 1, 28, 23, 59, 59, 3, 100), 1'b0, '0},
      '{-1, ActTick, '0, 1'b0, '0},
      '{-1, ActLoad, load_of(1900, 1, 28, 23, 59, 59, 0, 0), 1'b0, '0},
      '{-1, ActTick, '0, 1'b0, '0},
      '{-1, ActLoad, load_of(2000, 1, 28, 23, 59, 59, 1, 0), 1'b0, '0},
      '{-1, ActTick, '0, 1'b0, '0},
      '{-1, ActLoad, load_of(2100, 1, 28, 23, 59, 59, 2, 0), 1'b0, '0},
      '{-1, ActTick, '0, 1'b0, '0},
      // out-of-range fields at their widest
      '{-1, ActLoad, load_of(15, 15, 31, 31, 63, 63, 7, 64'h1234_5678), 1'b0, '0},
      '{-1, ActTick, '0, 1'b0, '0},
      '{-1, ActLoad, load_of(0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0},
      '{-1, ActTick, '0, 1'b0, '0},
      '{-1, ActLoad, load_of(2023, 0, 0, 23, 59, 59, 5, 0), 1'b0, '0},
      '{-1, ActTick, '0, 1'b0, '0},
      '{-1, ActLoad, load_of(2023, 3, 30, 23, 59, 59, 4, 0), 1'b0, '0},
      '{-1, ActTick, '0, 1'b0, '0}
    };
    phase_rate = '{16'd1, 16'd2, 16'd0, 16'd5, 16'd60, 16'($urandom_range(61, 65534)),
                   16'hFFFF, TpsReset};
    phase_len  = '{250, 250, 250, 250, 250, 250, 250, 250};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < 21; i++) begin
      if (plan[i].rate >= 0) set_tick_rate(16'(plan[i].rate));
      push_request(plan[i].act, plan[i].ld, plan[i].known, plan[i].want);
    end

    for (p = 0; p < 8; p++) begin
      set_tick_rate(phase_rate[p]);
      steady = (p == 2);
      load_pct = 15;
      repeat (phase_len[p]) begin
        raw = {$urandom, $urandom, $urandom};
        ld = raw[$bits(load_req_t)-1:0];
        if ($urandom_range(99) < load_pct) begin
          // Mostly valid dates poised just before a day, month or year rollover.
          if ($urandom_range(3) != 0) begin
            ld.year    = $urandom_range(1) ? 14'($urandom_range(162) * 100)
                                           : 14'($urandom_range(16383));
            ld.month   = 4'($urandom_range(11));
            ld.day     = 5'(days_in(ld.month, ld.year) - $urandom_range(1));
            ld.hour    = $urandom_range(1) ? 5'd23 : 5'($urandom_range(23));
            ld.minute  = $urandom_range(1) ? 6'd59 : 6'($urandom_range(59));
            ld.second  = 6'($urandom_range(59, 50));
            ld.weekday = 3'($urandom_range(6));
          end
          push_request(ActLoad, ld, 1'b0, '0);
        end else begin
          push_request(ActTick, ld, 1'b0, '0);
        end
      end
    end
    steady = 1'b0;

    wait_drain();
    $display("covered %0d ticks and %0d loads; %0d readings checked, %0d second pulses",
             tick_count, load_count, readings_checked, pulse_count);
    $display("tick rates 0 to 65535 incl. %0d; leap, century, wrap, out-of-range loads",
             phase_rate[5]);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
src/cal_clk_pkg.sv
src/cal_clk_in_stage.sv
src/cal_clk_core.sv
src/calendar_clock_counter_top.sv
verif/tb_calendar_clock_counter_top.sv
